// ===== rtl/rtd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared constants, widths and the run-descriptor queue entry for the
// run-length texel decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

   localparam int TEXEL_COUNT = 16384;

   // position counts 0..TEXEL_COUNT inclusive
   localparam int POS_W  = $clog2(TEXEL_COUNT + 1);
   localparam int WIDE_W = (POS_W > 16) ? POS_W : 16;

   localparam int FIELD_W = 15;
   localparam int WORD_W  = 16;
   localparam int LIT_W   = 9;

   localparam logic [WORD_W-1:0] LITERAL_BASE = 16'hFF00;
   localparam logic [16:0]       CODE_SPAN    = 17'h10000;
   localparam logic [WORD_W-1:0] OPAQUE_BIT   = 16'h8000;

   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic               run_valid;
      logic [FIELD_W-1:0] run_start;
      logic [FIELD_W-1:0] run_length;
      logic [WORD_W-1:0]  run_texel;
      logic               fill_valid;
      logic [FIELD_W-1:0] fill_start;
      logic [FIELD_W-1:0] fill_length;
   } entry_type;

   // run fields are reported modulo 32768
   function automatic logic [FIELD_W-1:0] to_field(input logic [WIDE_W-1:0] v);
      return v[FIELD_W-1:0];
   endfunction

endpackage : rtd_pkg
`default_nettype wire

// ===== rtl/rtd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_front
// Accepts stream items, tracks code/value/literal phase and texel position,
// and packs the resulting run and fill descriptors into one queue entry.
// ----------------------------------------------------------------------------
module rtd_front
   import rtd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [WORD_W-1:0] stream_word,
   input  wire logic              word_present,
   input  wire logic              stream_end,
   input  wire logic              csr_write_en,
   input  wire logic              csr_write_data,
   output logic                   q_push,
   output entry_type              q_entry
);

   typedef enum logic [1:0] {
      PH_CODE,
      PH_VALUE,
      PH_LITERAL
   } phase_type;

   localparam logic [POS_W-1:0] TOTAL = POS_W'(TEXEL_COUNT);

   phase_type          phase_ff, phase_in;
   logic [WORD_W-1:0]  rep_ff, rep_in;
   logic [LIT_W-1:0]   lit_ff, lit_in, lit_dec;
   logic [POS_W-1:0]   pos_ff, pos_in, pos_mid;
   logic               mode_ff;

   logic [POS_W-1:0]   room;
   logic [WIDE_W-1:0]  room_w, rep_w, len_w, run_len_w;
   logic               has_run;

   always_comb begin
      room    = TOTAL - pos_ff;
      room_w  = WIDE_W'(room);
      rep_w   = WIDE_W'(rep_ff);
      len_w   = (rep_w < room_w) ? rep_w : room_w;
      lit_dec = (lit_ff != '0) ? lit_ff - LIT_W'(1) : '0;

      phase_in  = phase_ff;
      rep_in    = rep_ff;
      lit_in    = lit_ff;
      pos_mid   = pos_ff;
      has_run   = 1'b0;
      run_len_w = WIDE_W'(1);

      if (word_present && (pos_ff < TOTAL)) begin
         if (!mode_ff) begin
            has_run = 1'b1;
            pos_mid = pos_ff + POS_W'(1);
         end else begin
            case (phase_ff)
               PH_VALUE: begin
                  has_run   = (len_w != '0);
                  run_len_w = len_w;
                  pos_mid   = pos_ff + POS_W'(len_w);
                  rep_in    = '0;
                  phase_in  = PH_CODE;
               end
               PH_LITERAL: begin
                  has_run = 1'b1;
                  pos_mid = pos_ff + POS_W'(1);
                  lit_in  = lit_dec;
                  if (lit_dec == '0) phase_in = PH_CODE;
               end
               PH_CODE: begin
                  if (stream_word < LITERAL_BASE) begin
                     rep_in   = stream_word;
                     phase_in = PH_VALUE;
                  end else begin
                     lit_in   = LIT_W'(CODE_SPAN - {1'b0, stream_word});
                     phase_in = PH_LITERAL;
                  end
               end
               default: phase_in = PH_CODE;
            endcase
         end
      end

      pos_in = pos_mid;
      if (stream_end) begin
         phase_in = PH_CODE;
         rep_in   = '0;
         lit_in   = '0;
         pos_in   = '0;
      end

      q_entry.run_valid   = has_run;
      q_entry.run_start   = to_field(WIDE_W'(pos_ff));
      q_entry.run_length  = to_field(run_len_w);
      q_entry.run_texel   = stream_word | OPAQUE_BIT;
      q_entry.fill_valid  = stream_end;
      q_entry.fill_start  = to_field(WIDE_W'(pos_mid));
      q_entry.fill_length = to_field(WIDE_W'(TOTAL - pos_mid));

      q_push = accept && (has_run || stream_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CODE;
         rep_ff   <= '0;
         lit_ff   <= '0;
         pos_ff   <= '0;
         mode_ff  <= 1'b1;
      end else begin
         if (csr_write_en) mode_ff <= csr_write_data;
         if (accept) begin
            phase_ff <= phase_in;
            rep_ff   <= rep_in;
            lit_ff   <= lit_in;
            pos_ff   <= pos_in;
         end
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= TOTAL)
      else $error("texel position beyond texture size");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && stream_end |=> pos_ff == '0 && phase_ff == PH_CODE && lit_ff == '0)
      else $error("decoder state not restarted after stream end");

endmodule : rtd_front
`default_nettype wire

// ===== rtl/rtd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_queue
// Short descriptor queue that decouples the decode front from the output
// back end.
// ----------------------------------------------------------------------------
module rtd_queue
   import rtd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  entry_type push_entry,
   input  wire logic pop,
   output entry_type head_entry,
   output logic      full,
   output logic      empty
);

   entry_type         mem_ff [QDEPTH];
   logic [QIDX_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QIDX_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QIDX_W'(1);
         if (push && !pop)      count_ff <= count_ff + QCNT_W'(1);
         else if (!push && pop) count_ff <= count_ff - QCNT_W'(1);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full descriptor queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty descriptor queue");

endmodule : rtd_queue
`default_nettype wire

// ===== rtl/rtd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_back
// Output stage: takes queue entries and presents their run and fill
// descriptors one per cycle on the result channel while the receiver pops.
// ----------------------------------------------------------------------------
module rtd_back
   import rtd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  entry_type                head_entry,
   input  wire logic                q_empty,
   output logic                     q_pop,
   input  wire logic                rsp_pop,
   output logic                     rsp_empty,
   output logic [FIELD_W-1:0]       rsp_run_start,
   output logic [FIELD_W-1:0]       rsp_run_length,
   output logic [WORD_W-1:0]        rsp_run_texel,
   output logic                     rsp_image_done
);

   entry_type entry_ff;
   logic      valid_ff, sel_fill_ff;
   logic      last_part, advance, to_fill;

   always_comb begin
      last_part = sel_fill_ff || !entry_ff.fill_valid;
      to_fill   = valid_ff && rsp_pop && !last_part;
      advance   = !valid_ff || (rsp_pop && last_part);
      q_pop     = advance && !q_empty;

      rsp_empty      = !valid_ff;
      rsp_image_done = sel_fill_ff;
      if (sel_fill_ff) begin
         rsp_run_start  = entry_ff.fill_start;
         rsp_run_length = entry_ff.fill_length;
         rsp_run_texel  = OPAQUE_BIT;
      end else begin
         rsp_run_start  = entry_ff.run_start;
         rsp_run_length = entry_ff.run_length;
         rsp_run_texel  = entry_ff.run_texel;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) entry_ff <= head_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         sel_fill_ff <= 1'b0;
      end else if (to_fill) begin
         sel_fill_ff <= 1'b1;
      end else if (advance) begin
         valid_ff    <= !q_empty;
         // an entry without a run opens on its fill descriptor
         sel_fill_ff <= !q_empty && !head_entry.run_valid;
      end
   end

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_pop |=> valid_ff && $stable(sel_fill_ff))
      else $error("result item changed while stalled");

endmodule : rtd_back
`default_nettype wire

// ===== rtl/rle_texel_run_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rle_texel_run_decoder_top
// Run-length texel stream decoder emitting run descriptors.
// A result reaches the rsp_ ports through the descriptor queue and then the
// output stage's entry register.
// Throughput: one item per cycle while the queue is not full; results leave at
// one per cycle while popped; a stream-ending item with a run yields two results.
// A four-entry descriptor queue sits between decode and output.
// Reset (synchronous, active high): compressed mode on, empty queue, position 0.
// ----------------------------------------------------------------------------
module rle_texel_run_decoder_top
   import rtd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [WORD_W-1:0]  req_stream_word,
   input  wire logic               req_word_present,
   input  wire logic               req_stream_end,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [FIELD_W-1:0]      rsp_run_start,
   output logic [FIELD_W-1:0]      rsp_run_length,
   output logic [WORD_W-1:0]       rsp_run_texel,
   output logic                    rsp_image_done,
   input  wire logic               csr_write_en,
   input  wire logic               csr_write_data
);

   entry_type push_entry, head_entry;
   logic      q_push, q_pop, q_empty, accept;

   assign accept = req_push && !req_full;

   rtd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .stream_word    (req_stream_word),
      .word_present   (req_word_present),
      .stream_end     (req_stream_end),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   rtd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (req_full),
      .empty      (q_empty)
   );

   rtd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_run_start  (rsp_run_start),
      .rsp_run_length (rsp_run_length),
      .rsp_run_texel  (rsp_run_texel),
      .rsp_image_done (rsp_image_done)
   );

endmodule : rle_texel_run_decoder_top
`default_nettype wire

// ===== sim/rle_texel_run_decoder_top_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rle_texel_run_decoder_top_test
// Checks the run-length texel decoder against a cycle-free model of its
// decode rules. Directed items hit code extremes, clipping, full texture,
// early stream end and mode changes mid-stream. Random streams follow, mostly
// well-formed code sequences with some noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module rle_texel_run_decoder_top_test
   import rtd_pkg::*;
();

   typedef struct {
      logic [WORD_W-1:0] stream_word;
      logic              word_present;
      logic              stream_end;
   } stream_item_type;

   typedef struct {
      logic [FIELD_W-1:0] run_start;
      logic [FIELD_W-1:0] run_length;
      logic [WORD_W-1:0]  run_texel;
      logic               image_done;
   } run_desc_type;

   typedef enum logic [1:0] {EXPECT_CODE, EXPECT_VALUE, IN_LITERAL} decode_phase_type;

   localparam logic [POS_W-1:0] FULL_POS  = POS_W'(TEXEL_COUNT);
   localparam int               LONG_HOLD = 300;
   localparam int               MAX_PRINT = 40;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_push         = 1'b0;
   logic                req_full;
   logic [WORD_W-1:0]   req_stream_word  = '0;
   logic                req_word_present = 1'b0;
   logic                req_stream_end   = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop          = 1'b0;
   logic [FIELD_W-1:0]  rsp_run_start;
   logic [FIELD_W-1:0]  rsp_run_length;
   logic [WORD_W-1:0]   rsp_run_texel;
   logic                rsp_image_done;
   logic                csr_write_en     = 1'b0;
   logic                csr_write_data   = 1'b0;

   rle_texel_run_decoder_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_stream_word  (req_stream_word),
      .req_word_present (req_word_present),
      .req_stream_end   (req_stream_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_run_start    (rsp_run_start),
      .rsp_run_length   (rsp_run_length),
      .rsp_run_texel    (rsp_run_texel),
      .rsp_image_done   (rsp_image_done),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // decoder state as the model sees it
   logic              mode_compressed;
   decode_phase_type  phase;
   logic [WORD_W-1:0] pending_repeat;
   logic [LIT_W-1:0]  literal_left;
   logic [POS_W-1:0]  texel_pos;

   stream_item_type stream_items[$];
   run_desc_type    runs_due[$];
   stream_item_type next_item;
   stream_item_type taken_item;

   int  errors        = 0;
   int  items_queued  = 0;
   int  items_taken   = 0;
   int  runs_checked  = 0;
   int  images_closed = 0;
   int  csr_writes    = 0;
   int  full_stalls   = 0;
   bit  req_taken     = 1'b0;

   int  burst_left    = 1;
   int  gap_left      = 0;

   int  stall_asked   = 0;
   int  stall_seen    = 0;
   int  hold_left     = 0;
   int  pat_left      = 0;
   logic [15:0] pop_pattern = '1;

   logic phase_modes [10] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

   task automatic flag_error(input string msg);
      if (errors < MAX_PRINT) $display("ERROR: %s", msg);
      errors++;
   endtask

   function automatic void restart_texture();
      phase          = EXPECT_CODE;
      pending_repeat = '0;
      literal_left   = '0;
      texel_pos      = '0;
   endfunction

   function automatic void push_run(input logic [POS_W-1:0] start,
                                    input logic [POS_W-1:0] len,
                                    input logic [WORD_W-1:0] texel,
                                    input logic done);
      run_desc_type r;
      r.run_start  = FIELD_W'(start);
      r.run_length = FIELD_W'(len);
      r.run_texel  = texel | OPAQUE_BIT;
      r.image_done = done;
      runs_due.push_back(r);
   endfunction

   // expected runs for one accepted item
   function automatic void predict_runs(input stream_item_type it);
      logic [POS_W-1:0] room;
      logic [POS_W-1:0] len;
      room = FULL_POS - texel_pos;
      if (it.word_present && texel_pos < FULL_POS) begin
         if (!mode_compressed) begin
            push_run(texel_pos, POS_W'(1), it.stream_word, 1'b0);
            texel_pos++;
         end else begin
            case (phase)
               EXPECT_VALUE: begin
                  len = (pending_repeat < WORD_W'(room)) ? POS_W'(pending_repeat) : room;
                  if (len != 0) begin
                     push_run(texel_pos, len, it.stream_word, 1'b0);
                     texel_pos += len;
                  end
                  pending_repeat = '0;
                  phase          = EXPECT_CODE;
               end
               IN_LITERAL: begin
                  push_run(texel_pos, POS_W'(1), it.stream_word, 1'b0);
                  texel_pos++;
                  if (literal_left != 0) literal_left--;
                  if (literal_left == 0) phase = EXPECT_CODE;
               end
               default: begin
                  if (it.stream_word < LITERAL_BASE) begin
                     pending_repeat = it.stream_word;
                     phase          = EXPECT_VALUE;
                  end else begin
                     literal_left = LIT_W'(CODE_SPAN - {1'b0, it.stream_word});
                     phase        = IN_LITERAL;
                  end
               end
            endcase
         end
      end
      if (it.stream_end) begin
         push_run(texel_pos, FULL_POS - texel_pos, '0, 1'b1);
         restart_texture();
      end
   endfunction

   task automatic check_run();
      run_desc_type want;
      if (runs_due.size() == 0) begin
         flag_error($sformatf("unexpected run start=%0d len=%0d texel=%h done=%b",
                    rsp_run_start, rsp_run_length, rsp_run_texel, rsp_image_done));
      end else begin
         want = runs_due.pop_front();
         if (rsp_run_start !== want.run_start || rsp_run_length !== want.run_length ||
             rsp_run_texel !== want.run_texel || rsp_image_done !== want.image_done)
            flag_error($sformatf("run got %0d/%0d/%h/%b want %0d/%0d/%h/%b",
                       rsp_run_start, rsp_run_length, rsp_run_texel, rsp_image_done,
                       want.run_start, want.run_length, want.run_texel, want.image_done));
         runs_checked++;
         if (want.image_done) images_closed++;
      end
   endtask

   // monitor: predicts on accepted items, checks accepted runs
   always @(posedge clock) begin
      if (reset) begin
         mode_compressed = 1'b1;
         restart_texture();
         req_taken = 1'b0;
      end else begin
         req_taken = req_push && !req_full;
         if (req_taken) begin
            taken_item.stream_word  = req_stream_word;
            taken_item.word_present = req_word_present;
            taken_item.stream_end   = req_stream_end;
            predict_runs(taken_item);
            items_taken++;
         end
         if (req_push && req_full) full_stalls++;
         if (csr_write_en) mode_compressed = csr_write_data;
         if (rsp_pop && !rsp_empty) check_run();
      end
   end

   // driver: bursts with random gaps, holds an item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !req_taken) begin
         // item still waiting on full
      end else if (gap_left > 0 || stream_items.size() == 0) begin
         if (gap_left > 0) gap_left--;
         req_push         <= 1'b0;
         req_stream_word  <= WORD_W'($urandom);
         req_word_present <= 1'($urandom);
         req_stream_end   <= 1'($urandom);
      end else begin
         next_item = stream_items.pop_front();
         req_push         <= 1'b1;
         req_stream_word  <= next_item.stream_word;
         req_word_present <= next_item.word_present;
         req_stream_end   <= next_item.stream_end;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
   end

   // receiver: pop pattern is redrawn whenever its countdown runs out, plus requested long holds
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (stall_seen != stall_asked) begin
            stall_seen = stall_asked;
            hold_left  = LONG_HOLD;
         end
         if (pat_left == 0) begin
            pat_left = 64;
            case ($urandom_range(0, 3))
               0: pop_pattern = '1;
               1: pop_pattern = 16'($urandom);
               2: pop_pattern = 16'($urandom) & 16'($urandom);
               default: pop_pattern = 16'hF0F0;
            endcase
         end
         pat_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= pop_pattern[pat_left[3:0]];
         end
      end
   end

   function automatic void add_item(input logic [WORD_W-1:0] w, input logic p,
                                    input logic e);
      stream_item_type it;
      it.stream_word  = w;
      it.word_present = p;
      it.stream_end   = e;
      stream_items.push_back(it);
      items_queued++;
   endfunction

   // input side idle and every expected run delivered
   task automatic wait_drained();
      bit in_idle;
      int guard;
      guard = 0;
      do begin
         @(posedge clock);
         in_idle = (stream_items.size() == 0) && !req_push;
         @(negedge clock);
         guard++;
      end while (!(in_idle && runs_due.size() == 0) && guard < 100000);
      if (runs_due.size() != 0)
         flag_error($sformatf("%0d runs never arrived", runs_due.size()));
   endtask

   task automatic set_mode(input logic m);
      wait_drained();
      // items with no run may still be in the pipe
      repeat (6) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      csr_writes++;
      @(posedge clock);
   endtask

   function automatic void gen_compressed_stream();
      int n_codes, count, n_lit, sel;
      n_codes = $urandom_range(1, 10);
      for (int k = 0; k < n_codes; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            if ($urandom_range(0, 19) == 0)      count = $urandom_range(16'h0800, 16'h3FFF);
            else if ($urandom_range(0, 49) == 0) count = $urandom_range(16'h4000, 16'hFEFF);
            else                                 count = $urandom_range(0, 40);
            add_item(WORD_W'(count), 1'b1, 1'b0);
            if ($urandom_range(0, 19) == 0) begin
               add_item(WORD_W'($urandom), 1'($urandom), 1'b1);
               return;
            end
            add_item(WORD_W'($urandom), 1'b1, 1'b0);
         end else if (sel < 90) begin
            n_lit = ($urandom_range(0, 59) == 0) ? 256 : $urandom_range(1, 8);
            add_item(WORD_W'(CODE_SPAN - n_lit), 1'b1, 1'b0);
            for (int j = 0; j < n_lit; j++) begin
               if (j > 0 && $urandom_range(0, 29) == 0) begin
                  add_item(WORD_W'($urandom), 1'b0, 1'b1);
                  return;
               end
               add_item(WORD_W'($urandom), 1'b1, 1'b0);
            end
         end else if (sel < 96) begin
            add_item(WORD_W'($urandom), 1'b0, 1'b0);
         end else begin
            add_item(WORD_W'($urandom), 1'b1, 1'b0);
         end
      end
      if ($urandom_range(0, 1)) add_item(WORD_W'($urandom), 1'b0, 1'b1);
      else                      stream_items[$].stream_end = 1'b1;
   endfunction

   function automatic void gen_raw_items(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4)       add_item(WORD_W'($urandom), 1'b0, 1'b0);
         else if (r < 8)  add_item(WORD_W'($urandom), 1'b0, 1'b1);
         else if (r < 12) add_item(WORD_W'($urandom), 1'b1, 1'b1);
         else             add_item(WORD_W'($urandom), 1'b1, 1'b0);
      end
   endfunction

   task automatic run_phase(input logic m, input int budget, input bit long_hold);
      int first;
      set_mode(m);
      if (long_hold) stall_asked++;
      first = items_queued;
      if (m) begin
         while (items_queued - first < budget / 2) gen_compressed_stream();
      end else begin
         gen_raw_items(budget / 2);
      end
      // sender pauses mid-phase until all runs are in
      wait_drained();
      @(posedge clock);
      if (m) begin
         while (items_queued - first < budget) gen_compressed_stream();
         // sometimes leave a code dangling into the next phase
         if ($urandom_range(0, 1)) add_item(WORD_W'($urandom_range(0, 20)), 1'b1, 1'b0);
      end else begin
         gen_raw_items(budget - budget / 2);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // compressed mode out of reset
      add_item(16'h0003, 1'b1, 1'b0); add_item(16'h0000, 1'b1, 1'b0);
      add_item(16'h0000, 1'b1, 1'b0); add_item(16'h1234, 1'b1, 1'b0);   // zero repeat
      add_item(16'hFFFF, 1'b1, 1'b0); add_item(16'hFFFF, 1'b1, 1'b0);   // one literal
      add_item(16'h5A5A, 1'b0, 1'b0);                                   // no-op item
      add_item(16'hFEFF, 1'b1, 1'b0); add_item(16'hABCD, 1'b1, 1'b0);   // clipped repeat
      add_item(16'h0005, 1'b1, 1'b0);                                   // texture full
      add_item(16'h1111, 1'b1, 1'b1);                                   // empty fill
      add_item(16'h0007, 1'b1, 1'b0); add_item(16'h0000, 1'b0, 1'b1);   // end awaiting value
      add_item(16'hFFF0, 1'b1, 1'b0); add_item(16'h0001, 1'b1, 1'b0);
      add_item(16'h8000, 1'b1, 1'b1);                                   // end inside literal
      add_item(16'hFFFF, 1'b0, 1'b1);                                   // end-only fill

      // code pending across a raw stretch, then resumed
      add_item(16'h3FFC, 1'b1, 1'b0); add_item(16'h2222, 1'b1, 1'b0);
      add_item(16'h0005, 1'b1, 1'b0);
      set_mode(1'b0);
      add_item(16'h7FFF, 1'b1, 1'b0); add_item(16'h0000, 1'b1, 1'b0);
      set_mode(1'b1);
      add_item(16'h4444, 1'b1, 1'b0); add_item(16'h0009, 1'b1, 1'b0);
      add_item(16'h0000, 1'b0, 1'b1);

      for (int p = 0; p < 10; p++) run_phase(phase_modes[p], 125, p == 1);
      // final phase left in compressed mode; close it out
      add_item(16'h0000, 1'b0, 1'b1);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d items, %0d runs checked, %0d textures closed",
               items_taken, runs_checked, images_closed);
      $display("Mode writes %0d, cycles with input held off by full %0d",
               csr_writes, full_stalls);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout waiting on the decoder");
      $display("Mismatches found");
      $finish;
   end

endmodule : rle_texel_run_decoder_top_test
`default_nettype wire
